// ===== design/epw_pkg.sv =====
// shared types, register indexes and constants for the esc pulse width mapper
package epw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN_US    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_CENTER_US = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX_US    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE_HZ   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_BITS       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_PCT    = 3'd7;

    typedef enum logic [1:0] {
        MODE_FWD        = 2'd0,
        MODE_BIDIR      = 2'd1,
        MODE_SAFE_FWD   = 2'd2,
        MODE_SAFE_BIDIR = 2'd3
    } mode_t;

    typedef struct packed {
        logic [15:0] input_min;
        logic [15:0] input_max;
        logic [15:0] pulse_min_us;
        logic [15:0] pulse_center_us;
        logic [15:0] pulse_max_us;
        logic [15:0] frame_rate_hz;
        logic [3:0]  duty_bits;
        logic [6:0]  deadband_pct;
    } cfg_t;

    // x / 100 as (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^23
    localparam logic [30:0] RECIP_100   = 31'd1374389535;
    localparam int          RECIP_SHIFT = 37;

    localparam int          MAP_Q_W    = 16;
    localparam int          PER_Q_W    = 20;
    localparam int          DUTY_Q_W   = 28;
    localparam logic [19:0] PERIOD_NUM = 20'd1000000;

    // classified command handed from front to back
    typedef struct packed {
        logic        direct;
        logic        neg;
        logic [15:0] base;
        logic [15:0] den;
        logic [31:0] num;
    } job_t;

endpackage

// ===== design/epw_front.sv =====
// front end: clamp, deadband decision and map numerator
module epw_front (
    input  logic               clk,
    input  logic               rst_n,
    input  epw_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        fwd_throttle,
    input  logic [15:0]        rev_throttle,
    input  logic [1:0]         mode,
    output logic               job_valid,
    input  logic               job_ready,
    output epw_pkg::job_t      job
);

    typedef struct packed {
        logic            valid;
        logic [15:0]     fi;
        logic [15:0]     ri;
        epw_pkg::mode_t  mode;
        logic            empty;
        logic [15:0]     span;
        logic [22:0]     prod;
    } f1_t;

    typedef struct packed {
        logic            valid;
        logic [15:0]     fi;
        logic [15:0]     ri;
        epw_pkg::mode_t  mode;
        logic            empty;
        logic [15:0]     span;
        logic [53:0]     thr_mul;
    } f2_t;

    typedef struct packed {
        logic        valid;
        logic        direct;
        logic        neg;
        logic [15:0] base;
        logic [15:0] den;
        logic [15:0] off;
        logic [15:0] mag;
    } f3_t;

    typedef struct packed {
        logic          valid;
        epw_pkg::job_t job;
    } f4_t;

    f1_t f1_reg, f1_next;
    f2_t f2_reg, f2_next;
    f3_t f3_reg, f3_next;
    f4_t f4_reg, f4_next;
    logic adv;

    function automatic logic [15:0] clamp_in(input logic [15:0] v, input logic [15:0] lo,
                                             input logic [15:0] hi);
        logic [15:0] r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    assign adv       = !f4_reg.valid || job_ready;
    assign in_ready  = adv;
    assign job_valid = f4_reg.valid;
    assign job       = f4_reg.job;

    always_comb
    begin
        f1_next.valid = in_valid;
        f1_next.fi    = clamp_in(fwd_throttle, cfg.input_min, cfg.input_max);
        f1_next.ri    = clamp_in(rev_throttle, cfg.input_min, cfg.input_max);
        f1_next.mode  = epw_pkg::mode_t'(mode);
        f1_next.empty = !(cfg.input_max > cfg.input_min);
        f1_next.span  = cfg.input_max - cfg.input_min;
        f1_next.prod  = {7'd0, f1_next.span} * {16'd0, cfg.deadband_pct};
    end

    always_comb
    begin
        f2_next.valid   = f1_reg.valid;
        f2_next.fi      = f1_reg.fi;
        f2_next.ri      = f1_reg.ri;
        f2_next.mode    = f1_reg.mode;
        f2_next.empty   = f1_reg.empty;
        f2_next.span    = f1_reg.span;
        f2_next.thr_mul = {31'd0, f1_reg.prod} * {23'd0, epw_pkg::RECIP_100};
    end

    always_comb
    begin
        logic [15:0] thr;
        logic        fwd_win;
        logic [15:0] sel;
        logic [15:0] o_start;
        logic [15:0] o_end;
        logic [16:0] diff;
        logic [16:0] magw;
        thr     = cfg.input_min + f2_reg.thr_mul[epw_pkg::RECIP_SHIFT +: 16];
        fwd_win = (f2_reg.fi > thr) && (f2_reg.ri < f2_reg.fi);
        sel     = f2_reg.fi;
        o_start = cfg.pulse_min_us;
        o_end   = cfg.pulse_max_us;
        f3_next.direct = f2_reg.empty;
        case (f2_reg.mode)
            epw_pkg::MODE_FWD:
            begin
                sel     = f2_reg.fi;
                o_start = cfg.pulse_min_us;
                o_end   = cfg.pulse_max_us;
            end
            epw_pkg::MODE_BIDIR:
            begin
                sel     = fwd_win ? f2_reg.fi : f2_reg.ri;
                o_start = cfg.pulse_center_us;
                o_end   = fwd_win ? cfg.pulse_max_us : cfg.pulse_min_us;
            end
            epw_pkg::MODE_SAFE_FWD:
            begin
                o_start        = cfg.pulse_min_us;
                o_end          = cfg.pulse_min_us;
                f3_next.direct = 1'b1;
            end
            default:
            begin
                o_start        = cfg.pulse_center_us;
                o_end          = cfg.pulse_center_us;
                f3_next.direct = 1'b1;
            end
        endcase
        diff          = {1'b0, o_end} - {1'b0, o_start};
        magw          = diff[16] ? (17'd0 - diff) : diff;
        f3_next.valid = f2_reg.valid;
        f3_next.neg   = diff[16];
        f3_next.mag   = magw[15:0];
        f3_next.base  = o_start;
        f3_next.den   = f2_reg.span;
        f3_next.off   = sel - cfg.input_min;
    end

    always_comb
    begin
        f4_next.valid      = f3_reg.valid;
        f4_next.job.direct = f3_reg.direct;
        f4_next.job.neg    = f3_reg.neg;
        f4_next.job.base   = f3_reg.base;
        f4_next.job.den    = f3_reg.den;
        f4_next.job.num    = {16'd0, f3_reg.off} * {16'd0, f3_reg.mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg <= '0;
            f2_reg <= '0;
            f3_reg <= '0;
            f4_reg <= '0;
        end
        else if (adv)
        begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
            f4_reg <= f4_next;
        end
    end

endmodule

// ===== design/epw_queue.sv =====
// two-entry queue between front and back
module epw_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  epw_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output epw_pkg::job_t pop_data
);

    epw_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/epw_back.sv =====
// back end: pipelined map and period division, duty division, output register
module epw_back (
    input  logic          clk,
    input  logic          rst_n,
    input  epw_pkg::cfg_t cfg,
    input  logic          job_valid,
    output logic          job_ready,
    input  epw_pkg::job_t job,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [15:0]   pulse_width,
    output logic [15:0]   duty
);

    typedef struct packed {
        logic                          valid;
        logic                          direct;
        logic                          neg;
        logic [15:0]                   base;
        logic [15:0]                   den;
        logic [31:0]                   rem;
        logic [epw_pkg::MAP_Q_W-1:0]   qm;
        logic [19:0]                   rper;
        logic [epw_pkg::PER_Q_W-1:0]   qp;
    } mstage_t;

    typedef struct packed {
        logic        valid;
        logic        bad;
        logic [15:0] pulse;
        logic [19:0] period;
    } pstage_t;

    typedef struct packed {
        logic                          valid;
        logic                          bad;
        logic [15:0]                   pulse;
        logic [19:0]                   period;
        logic [30:0]                   rem;
        logic [epw_pkg::DUTY_Q_W-1:0]  q;
    } dstage_t;

    mstage_t     mst_reg  [epw_pkg::PER_Q_W+1];
    mstage_t     mst_next [epw_pkg::PER_Q_W+1];
    pstage_t     pst_reg, pst_next;
    dstage_t     dst_reg  [epw_pkg::DUTY_Q_W+1];
    dstage_t     dst_next [epw_pkg::DUTY_Q_W+1];
    logic        out_valid_reg;
    logic [15:0] pulse_reg, duty_reg;
    logic        adv;

    assign adv         = !out_valid_reg || out_ready;
    assign job_ready   = adv;
    assign out_valid   = out_valid_reg;
    assign pulse_width = pulse_reg;
    assign duty        = duty_reg;

    // map quotient one bit a stage, frame period one bit a stage alongside
    always_comb
    begin
        logic [31:0] mcmp;
        logic [35:0] pcmp;
        mst_next[0].valid  = job_valid;
        mst_next[0].direct = job.direct;
        mst_next[0].neg    = job.neg;
        mst_next[0].base   = job.base;
        mst_next[0].den    = job.den;
        mst_next[0].rem    = job.num;
        mst_next[0].qm     = '0;
        mst_next[0].rper   = epw_pkg::PERIOD_NUM;
        mst_next[0].qp     = '0;
        for (int k = 0; k < epw_pkg::PER_Q_W; k++)
        begin
            mst_next[k+1] = mst_reg[k];
            if (k < epw_pkg::MAP_Q_W)
            begin
                mcmp = {16'd0, mst_reg[k].den} << (epw_pkg::MAP_Q_W - 1 - k);
                if (mst_reg[k].rem >= mcmp)
                begin
                    mst_next[k+1].rem                        = mst_reg[k].rem - mcmp;
                    mst_next[k+1].qm[epw_pkg::MAP_Q_W-1-k]   = 1'b1;
                end
            end
            pcmp = {20'd0, cfg.frame_rate_hz} << (epw_pkg::PER_Q_W - 1 - k);
            if ({16'd0, mst_reg[k].rper} >= pcmp)
            begin
                mst_next[k+1].rper                      = mst_reg[k].rper - pcmp[19:0];
                mst_next[k+1].qp[epw_pkg::PER_Q_W-1-k]  = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [15:0] qv;
        qv              = mst_reg[epw_pkg::PER_Q_W].qm;
        pst_next.valid  = mst_reg[epw_pkg::PER_Q_W].valid;
        pst_next.bad    = (cfg.frame_rate_hz == 16'd0) || (cfg.duty_bits == 4'd0);
        pst_next.period = mst_reg[epw_pkg::PER_Q_W].qp;
        if (mst_reg[epw_pkg::PER_Q_W].direct)
            pst_next.pulse = mst_reg[epw_pkg::PER_Q_W].base;
        else if (mst_reg[epw_pkg::PER_Q_W].neg)
            pst_next.pulse = mst_reg[epw_pkg::PER_Q_W].base - qv;
        else
            pst_next.pulse = mst_reg[epw_pkg::PER_Q_W].base + qv;
    end

    // duty = pulse * top / period, quotient one bit a stage
    always_comb
    begin
        logic [15:0] top_w;
        logic [47:0] dcmp;
        top_w              = (16'd1 << cfg.duty_bits) - 16'd1;
        dst_next[0].valid  = pst_reg.valid;
        dst_next[0].bad    = pst_reg.bad;
        dst_next[0].pulse  = pst_reg.pulse;
        dst_next[0].period = pst_reg.period;
        dst_next[0].rem    = {15'd0, pst_reg.pulse} * {16'd0, top_w[14:0]};
        dst_next[0].q      = '0;
        for (int k = 0; k < epw_pkg::DUTY_Q_W; k++)
        begin
            dst_next[k+1] = dst_reg[k];
            dcmp = {28'd0, dst_reg[k].period} << (epw_pkg::DUTY_Q_W - 1 - k);
            if ({17'd0, dst_reg[k].rem} >= dcmp)
            begin
                dst_next[k+1].rem                         = dst_reg[k].rem - dcmp[30:0];
                dst_next[k+1].q[epw_pkg::DUTY_Q_W-1-k]    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= epw_pkg::PER_Q_W; k++)
                mst_reg[k] <= '0;
            pst_reg <= '0;
            for (int k = 0; k <= epw_pkg::DUTY_Q_W; k++)
                dst_reg[k] <= '0;
            out_valid_reg <= 1'b0;
            pulse_reg     <= '0;
            duty_reg      <= '0;
        end
        else if (adv)
        begin
            for (int k = 0; k <= epw_pkg::PER_Q_W; k++)
                mst_reg[k] <= mst_next[k];
            pst_reg <= pst_next;
            for (int k = 0; k <= epw_pkg::DUTY_Q_W; k++)
                dst_reg[k] <= dst_next[k];
            out_valid_reg <= dst_reg[epw_pkg::DUTY_Q_W].valid;
            pulse_reg     <= dst_reg[epw_pkg::DUTY_Q_W].pulse;
            duty_reg      <= dst_reg[epw_pkg::DUTY_Q_W].bad ? 16'd0
                                                           : dst_reg[epw_pkg::DUTY_Q_W].q[15:0];
        end
    end

endmodule

// ===== design/esc_pulse_width_mapper_core.sv =====
// top level of the esc pulse width mapper: config registers, front, queue, back
// throughput: one transfer per cycle when nothing stalls, set by the fully pipelined dividers
//   (20 stages for map quotient and frame period, 28 stages for the duty word)
// reset: rst_n asynchronous, active low; config registers return to defaults,
//   every pipeline stage and the queue are emptied
module esc_pulse_width_mapper_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [epw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [epw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [15:0]                     fwd_throttle,
    input  logic [15:0]                     rev_throttle,
    input  logic [1:0]                      mode,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [15:0]                     pulse_width,
    output logic [15:0]                     duty
);

    // configuration registers; write only while no transfer is in flight, the block does not check
    epw_pkg::cfg_t cfg_reg, cfg_next;

    // front to queue and queue to back
    logic          f_valid, f_ready;
    epw_pkg::job_t f_job;
    logic          b_valid, b_ready;
    epw_pkg::job_t b_job;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                epw_pkg::CFG_INPUT_MIN:       cfg_next.input_min       = cfg_data;
                epw_pkg::CFG_INPUT_MAX:       cfg_next.input_max       = cfg_data;
                epw_pkg::CFG_PULSE_MIN_US:    cfg_next.pulse_min_us    = cfg_data;
                epw_pkg::CFG_PULSE_CENTER_US: cfg_next.pulse_center_us = cfg_data;
                epw_pkg::CFG_PULSE_MAX_US:    cfg_next.pulse_max_us    = cfg_data;
                epw_pkg::CFG_FRAME_RATE_HZ:   cfg_next.frame_rate_hz   = cfg_data;
                epw_pkg::CFG_DUTY_BITS:       cfg_next.duty_bits       = cfg_data[3:0];
                epw_pkg::CFG_DEADBAND_PCT:    cfg_next.deadband_pct    = cfg_data[6:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_min       <= 16'd1000;
            cfg_reg.input_max       <= 16'd2000;
            cfg_reg.pulse_min_us    <= 16'd1000;
            cfg_reg.pulse_center_us <= 16'd1500;
            cfg_reg.pulse_max_us    <= 16'd2000;
            cfg_reg.frame_rate_hz   <= 16'd50;
            cfg_reg.duty_bits       <= 4'd14;
            cfg_reg.deadband_pct    <= 7'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // clamp, classify and form the map numerator
    epw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .fwd_throttle (fwd_throttle),
        .rev_throttle (rev_throttle),
        .mode         (mode),
        .job_valid    (f_valid),
        .job_ready    (f_ready),
        .job          (f_job)
    );

    // lets the front keep taking transfers while the back is stalled, until its two entries are full
    epw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_job)
    );

    // divisions and the output register
    epw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job_valid   (b_valid),
        .job_ready   (b_ready),
        .job         (b_job),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pulse_width (pulse_width),
        .duty        (duty)
    );

    // bad pwm settings must force the duty word to zero
    a_duty_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cfg_reg.frame_rate_hz == 16'd0) |-> (duty == 16'd0))
        else $error("duty not zero with zero frame rate");

    a_duty_zero_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cfg_reg.duty_bits == 4'd0) |-> (duty == 16'd0))
        else $error("duty not zero with zero duty bits");

    // front only stalls when its last stage holds an item the queue cannot take
    a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (f_valid && !f_ready))
        else $error("front stalled without a blocked item");

endmodule
